@@ hdl/r2fft_pkg.sv @@
// ----------------------------------------------------------------------------
// r2fft_pkg: shared constants, types and twiddle table
// Constants and the quarter-wave cosine table for the radix-2 FFT core.
// ----------------------------------------------------------------------------
`default_nettype none

package r2fft_pkg;

  localparam int FFT_SIZE_DEF = 128;
  localparam int ROM_POINTS   = 128;
  localparam int DATA_W       = 24;
  localparam int SAMPLE_W     = 16;
  localparam int TW_W         = 16;
  localparam int BIN_W        = 6;
  localparam int MAG_W        = 16;
  localparam logic [16:0] MAG_MAX = 17'd32768;

  typedef logic signed [DATA_W-1:0] word_t;

  // round(32768*cos(pi*k/64)) for k = 0..32, full scale saturated.
  function automatic logic [TW_W-1:0] quarter_cos(input logic [5:0] k);
    logic [TW_W-1:0] v;
    case (k)
      6'd0:  v = 16'd32767; 6'd1:  v = 16'd32729; 6'd2:  v = 16'd32610;
      6'd3:  v = 16'd32413; 6'd4:  v = 16'd32138; 6'd5:  v = 16'd31786;
      6'd6:  v = 16'd31357; 6'd7:  v = 16'd30853; 6'd8:  v = 16'd30274;
      6'd9:  v = 16'd29622; 6'd10: v = 16'd28899; 6'd11: v = 16'd28106;
      6'd12: v = 16'd27246; 6'd13: v = 16'd26320; 6'd14: v = 16'd25330;
      6'd15: v = 16'd24279; 6'd16: v = 16'd23170; 6'd17: v = 16'd22006;
      6'd18: v = 16'd20788; 6'd19: v = 16'd19520; 6'd20: v = 16'd18205;
      6'd21: v = 16'd16846; 6'd22: v = 16'd15447; 6'd23: v = 16'd14010;
      6'd24: v = 16'd12540; 6'd25: v = 16'd11039; 6'd26: v = 16'd9512;
      6'd27: v = 16'd7962;  6'd28: v = 16'd6393;  6'd29: v = 16'd4808;
      6'd30: v = 16'd3212;  6'd31: v = 16'd1608;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/radix2_fft_magnitude_spectrum_core.sv @@
// ----------------------------------------------------------------------------
// radix2_fft_magnitude_spectrum_core
// Real-input radix-2 DIT FFT with one shared butterfly and an iterative
// square root, emitting the magnitudes of the lower half of the spectrum.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_*    | in  | tdata[15:0] sample
//  out_*   | out | tdata[5:0] bin_index, tdata[21:6] magnitude; tlast = last
//
//  Loading accepts one item per cycle into the work memory at the bit-reversed
//  address. The last item of a frame starts the transform: (N/2)*log2(N)
//  butterflies, each in the steps read a, read b, twiddle, multiply, add and
//  write a, write b. Each magnitude then goes through read, square, the
//  iterative square root and presentation. Input is held off while the
//  transform and the output run; a stalled output holds its item. Reset
//  (rst_n low, synchronous) clears only control; no memory clearing.
`default_nettype none

module radix2_fft_magnitude_spectrum_core
  import r2fft_pkg::*;
#(
  parameter int FFT_SIZE = FFT_SIZE_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [15:0] sample
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [5:0] bin_index, [21:6] magnitude, pad
  output logic        out_tlast
);

  localparam int LG  = (FFT_SIZE <= 4) ? 2 : (FFT_SIZE <= 8) ? 3 :
                       (FFT_SIZE <= 16) ? 4 : (FFT_SIZE <= 32) ? 5 :
                       (FFT_SIZE <= 64) ? 6 : 7;
  localparam int N   = 1 << LG;
  localparam int AW  = LG;

  localparam logic [3:0] S_LOAD = 4'd0, S_RA = 4'd1, S_RB = 4'd2,
                         S_MUL = 4'd3, S_SUM = 4'd4, S_WA = 4'd5,
                         S_WB = 4'd6, S_MRD = 4'd7, S_MSQ = 4'd8,
                         S_SQ = 4'd9, S_OUT = 4'd10, S_MRW = 4'd11;

  logic [3:0] state_r, state_nxt;

  // work memory: real and imaginary parts in one word
  logic [2*DATA_W-1:0] mem [N];
  logic [2*DATA_W-1:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [2*DATA_W-1:0] wr_data;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  logic [AW-1:0] load_r, load_nxt;
  logic [2:0] stage_r, stage_nxt;       // span = 2 << stage
  logic [AW-1:0] bfly_r, bfly_nxt;      // butterfly counter
  logic [AW-1:0] bin_r, bin_nxt;

  word_t ur_r, ui_r, xr_r, xi_r;
  logic signed [TW_W:0] c_r, s_r;
  logic signed [40:0] p1_r, p2_r, p3_r, p4_r;
  word_t br_r, bi_r;
  word_t ar_v, ai_v, br_v, bi_v;

  // square root unit
  logic [47:0] rad_r, rem_nxt_v;
  logic [47:0] root_r, bit_r;
  logic [47:0] rem_r;
  logic [47:0] sq_re_r;
  logic [15:0] mag_r;
  logic [5:0] obin_r;
  logic olast_r;
  word_t m_re, m_im;

  assign m_re = rd_q[2*DATA_W-1:DATA_W];
  assign m_im = rd_q[DATA_W-1:0];

  function automatic logic [AW-1:0] rev(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int i = 0; i < AW; i++) r[i] = v[AW-1-i];
    return r;
  endfunction

  // butterfly addresses: half = 1 << stage
  logic [AW-1:0] half, j_idx, k_base, a_addr, b_addr;
  logic [6:0] tw;
  logic [5:0] tq;
  logic signed [TW_W:0] c_v, s_v;
  always_comb begin
    half   = AW'(1) << stage_r;
    j_idx  = bfly_r & (half - AW'(1));
    k_base = (bfly_r & ~(half - AW'(1))) << 1;
    a_addr = k_base | j_idx;
    b_addr = a_addr | half;
    tw     = 7'(j_idx) << (3'd6 - stage_r);
    tq     = tw[5:0];
    if (tq <= 6'd32) begin
      c_v = {1'b0, quarter_cos(tq)};
      s_v = {1'b0, quarter_cos(6'd32 - tq)};
    end else begin
      c_v = -$signed({1'b0, quarter_cos(6'd0 - tq)});
      s_v = {1'b0, quarter_cos(tq - 6'd32)};
    end
  end

  function automatic word_t sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) return 24'sh7FFFFF;
    if (v < -26'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  logic signed [42:0] tr_sum, ti_sum;
  logic signed [25:0] tr_v, ti_v;
  always_comb begin
    tr_sum = 43'(p1_r) + 43'(p2_r) + 43'sd16384;
    ti_sum = 43'(p3_r) - 43'(p4_r) + 43'sd16384;
    tr_v = tr_sum[40:15];
    ti_v = ti_sum[40:15];
  end

  // The upper output is written straight from the adders; the lower one is
  // registered for the following write.
  always_comb begin
    ar_v = sat24(26'(ur_r) + tr_v);
    ai_v = sat24(26'(ui_r) + ti_v);
    br_v = sat24(26'(ur_r) - tr_v);
    bi_v = sat24(26'(ui_r) - ti_v);
  end

  logic last_bfly;
  assign last_bfly = (bfly_r == AW'(N/2 - 1));
  logic [47:0] trial;
  assign trial = root_r + bit_r;
  assign rem_nxt_v = rem_r - trial;

  logic [47:0] mshift;
  assign mshift = root_r >> LG;

  always_comb begin
    state_nxt = state_r;
    load_nxt = load_r;
    stage_nxt = stage_r;
    bfly_nxt = bfly_r;
    bin_nxt = bin_r;
    rd_addr = a_addr;
    wr_en = 1'b0;
    wr_addr = a_addr;
    wr_data = {ar_v, ai_v};
    in_tready = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        wr_addr = rev(load_r);
        wr_data = {DATA_W'($signed(in_tdata)), DATA_W'(0)};
        if (in_tvalid) begin
          wr_en = 1'b1;
          load_nxt = load_r + AW'(1);
          if (load_r == AW'(N - 1)) begin
            stage_nxt = 3'd0;
            bfly_nxt = '0;
            state_nxt = S_RA;
          end
        end
      end
      S_RA: begin rd_addr = a_addr; state_nxt = S_RB; end
      S_RB: begin rd_addr = b_addr; state_nxt = S_MUL; end
      S_MUL: state_nxt = S_SUM;
      S_SUM: state_nxt = S_WA;
      S_WA: begin
        wr_en = 1'b1; wr_addr = a_addr; wr_data = {ar_v, ai_v};
        state_nxt = S_WB;
      end
      S_WB: begin
        wr_en = 1'b1; wr_addr = b_addr; wr_data = {br_r, bi_r};
        bfly_nxt = bfly_r + AW'(1);
        state_nxt = S_RA;
        if (last_bfly) begin
          bfly_nxt = '0;
          stage_nxt = stage_r + 3'd1;
          if (stage_r == 3'(LG - 1)) begin
            bin_nxt = '0;
            state_nxt = S_MRD;
          end
        end
      end
      S_MRD: begin rd_addr = bin_r; state_nxt = S_MRW; end
      S_MRW: begin rd_addr = bin_r; state_nxt = S_MSQ; end
      S_MSQ: state_nxt = S_SQ;
      S_SQ: if (bit_r == 48'd0 && root_r != 48'hFFFF_FFFF_FFFF) state_nxt = S_OUT;
      S_OUT: if (out_tready) begin
        bin_nxt = bin_r + AW'(1);
        state_nxt = S_MRD;
        if (bin_r == AW'(N/2 - 1)) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      load_r <= '0;
      stage_r <= '0;
      bfly_r <= '0;
      bin_r <= '0;
    end else begin
      state_r <= state_nxt;
      load_r <= load_nxt;
      stage_r <= stage_nxt;
      bfly_r <= bfly_nxt;
      bin_r <= bin_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_RB: {ur_r, ui_r} <= rd_q;
      S_MUL: begin
        {xr_r, xi_r} <= rd_q;
        c_r <= c_v;
        s_r <= s_v;
      end
      S_SUM: begin
        p1_r <= 41'(c_r) * 41'(xr_r);
        p2_r <= 41'(s_r) * 41'(xi_r);
        p3_r <= 41'(c_r) * 41'(xi_r);
        p4_r <= 41'(s_r) * 41'(xr_r);
      end
      S_WA: begin
        br_r <= br_v;
        bi_r <= bi_v;
      end
      S_MSQ: begin
        xr_r <= rd_q[2*DATA_W-1:DATA_W];
        xi_r <= rd_q[DATA_W-1:0];
      end
      default: ;
    endcase
  end

  // Square root: squares registered first, then one bit pair per cycle.
  always_ff @(posedge clk) begin
    if (state_r == S_MSQ) begin
      sq_re_r <= 48'(m_re) * 48'(m_re);
      rad_r <= 48'(m_im) * 48'(m_im);
      bit_r <= 48'd0;
    end else if (state_r == S_SQ && bit_r == 48'd0 && root_r == 48'hFFFF_FFFF_FFFF) begin
      bit_r <= 48'd0;
    end
    if (state_r == S_MSQ) begin
      root_r <= 48'hFFFF_FFFF_FFFF;
    end else if (state_r == S_SQ) begin
      if (root_r == 48'hFFFF_FFFF_FFFF) begin
        rem_r <= sq_re_r + rad_r;
        root_r <= '0;
        bit_r <= 48'h4000_0000_0000;
      end else if (bit_r != 48'd0) begin
        if (rem_r >= trial) begin
          rem_r <= rem_nxt_v;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
    end
    if (state_r == S_SQ) begin
      mag_r <= (mshift > 48'(MAG_MAX)) ? 16'(MAG_MAX) : mshift[15:0];
      obin_r <= 6'(bin_r);
      olast_r <= (bin_r == AW'(N/2 - 1));
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {2'b00, mag_r, obin_r};
  assign out_tlast = olast_r;

endmodule

`default_nettype wire

@@ tb/radix2_fft_magnitude_spectrum_core_tb.sv @@
// ----------------------------------------------------------------------------
// radix2_fft_magnitude_spectrum_core_tb
// Streams real samples into the FFT core in frames of FFT_SIZE items, computes
// the expected bin magnitudes with a fixed-point FFT of its own, and checks
// every output item in order, with random bursts on the input side and random
// backpressure on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module radix2_fft_magnitude_spectrum_core_tb;
  import r2fft_pkg::*;

  localparam int N       = FFT_SIZE_DEF;
  localparam int LG      = $clog2(N);
  localparam int NFRAMES = 3;            // the first frame is directed
  localparam int NSAMPLES = 330;         // the last frame stays partial
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [5:0]  bin_index;
    logic [15:0] magnitude;
    logic        last;
  } bin_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;

  logic [15:0] sample_q[$];
  bin_t        bins_q[$];
  logic signed [23:0] fr_re[N];
  logic signed [23:0] fr_im[N];
  int          load_idx;
  int          errors;
  int          bins_seen;
  int          frames_done;
  int          idle_cycles;
  int          burst_left;
  int          gap_left;
  int          stall_phase;

  // The handshake state of the last rising edge, so the driver advances only
  // after an item has actually been taken.
  logic in_tready_seen;

  radix2_fft_magnitude_spectrum_core #(.FFT_SIZE(N)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sd8388607;
    if (v < -64'sd8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void twiddle(input int t, output longint c, output longint s);
    t = t & 63;
    if (t <= 32) begin
      c = quarter_cos(6'(t));
      s = quarter_cos(6'(32 - t));
    end else begin
      c = -longint'(quarter_cos(6'(64 - t)));
      s = quarter_cos(6'(t - 32));
    end
  endfunction

  // Runs the transform over the loaded frame and queues the expected bins.
  task automatic compute_spectrum();
    longint c, s, xr, xi, tr, ti, ur, ui;
    longint re, im;
    logic [63:0] m;
    int a, b;
    bin_t e;
    for (int sp = 2; sp <= N; sp = sp * 2) begin
      for (int k = 0; k < N; k += sp) begin
        for (int j = 0; j < sp / 2; j++) begin
          a = k + j;
          b = k + j + sp / 2;
          twiddle(j * (ROM_POINTS / sp), c, s);
          xr = fr_re[b];
          xi = fr_im[b];
          tr = (c * xr + s * xi + 16384) >>> 15;
          ti = (c * xi - s * xr + 16384) >>> 15;
          ur = fr_re[a];
          ui = fr_im[a];
          fr_re[a] = sat24(ur + tr);
          fr_im[a] = sat24(ui + ti);
          fr_re[b] = sat24(ur - tr);
          fr_im[b] = sat24(ui - ti);
        end
      end
    end
    for (int k = 0; k < N / 2; k++) begin
      re = fr_re[k];
      im = fr_im[k];
      m = isqrt(64'(re * re) + 64'(im * im)) >> LG;
      if (m > 64'(MAG_MAX)) m = 64'(MAG_MAX);
      e.bin_index = 6'(k);
      e.magnitude = m[15:0];
      e.last      = (k == N / 2 - 1);
      bins_q.push_back(e);
    end
  endtask

  task automatic load_sample(input logic [15:0] x);
    int pos;
    pos = 0;
    for (int i = 0; i < LG; i++) pos = (pos << 1) | ((load_idx >> i) & 1);
    fr_re[pos] = $signed(x);
    fr_im[pos] = 0;
    if (load_idx == N - 1) begin
      load_idx = 0;
      compute_spectrum();
    end else begin
      load_idx++;
    end
  endtask

  // Stimulus: a directed frame of full-scale alternating samples with a few
  // small values, then random frames, the last one cut short.
  initial begin
    int kind;
    rst_n = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (i < 4) sample_q.push_back(i[0] ? 16'h8000 : 16'h7FFF);
      else if (i < 8) sample_q.push_back(i[0] ? 16'hFFFF : 16'h0000);
      else sample_q.push_back(i[0] ? 16'h8000 : 16'h7FFF);
    end
    for (int f = 1; f < NFRAMES; f++) begin
      kind = $urandom_range(0, 3);
      for (int i = 0; i < N; i++) begin
        case (kind)
          0: sample_q.push_back(16'($urandom));
          1: sample_q.push_back(16'($signed($urandom_range(0, 2000)) - 1000));
          2: sample_q.push_back((i % 4 < 2) ? 16'h7FFF : 16'h8000);
          default: sample_q.push_back((i == 0) ? 16'($urandom) : 16'h0000);
        endcase
      end
    end
    while (sample_q.size() > NSAMPLES) void'(sample_q.pop_back());
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Driver: bursts of random length with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_tvalid || in_tready_seen) begin
      if (gap_left > 0 || sample_q.size() == 0) begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= sample_q.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor and checker.
  always @(posedge clk) begin
    bin_t e;
    logic [5:0]  got_bin;
    logic [15:0] got_mag;
    if (!rst_n) begin
      in_tready_seen <= 1'b0;
      load_idx       = 0;
      errors         = 0;
      bins_seen      = 0;
      frames_done    = 0;
      idle_cycles    = 0;
      stall_phase    = 0;
    end else begin
      in_tready_seen <= in_tvalid && in_tready;
      idle_cycles = idle_cycles + 1;
      if (in_tvalid && in_tready) begin
        load_sample(in_tdata);
        idle_cycles = 0;
      end
      if (out_tvalid && out_tready) begin
        idle_cycles = 0;
        bins_seen++;
        got_bin = out_tdata[5:0];
        got_mag = out_tdata[21:6];
        if (bins_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected bin %0d magnitude %0d", got_bin, got_mag);
        end else begin
          e = bins_q.pop_front();
          if (got_bin !== e.bin_index || got_mag !== e.magnitude
              || out_tlast !== e.last) begin
            errors++;
            if (errors <= 10)
              $display({"bin mismatch: exp bin %0d mag %0d last %0b, ",
                        "got bin %0d mag %0d last %0b"},
                       e.bin_index, e.magnitude, e.last, got_bin, got_mag, out_tlast);
          end
          if (e.last) frames_done++;
        end
      end
      stall_phase = (stall_phase + 1) % 23;
    end
  end

  // Receiver stalls on a fixed irregular pattern plus random drops.
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= (stall_phase < 12) ? 1'b1
                     : (stall_phase < 16) ? 1'b0 : ($urandom_range(0, 3) != 0);
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (sample_q.size() == 0 && !in_tvalid && bins_q.size() == 0) break;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no traffic for %0d cycles", WATCHDOG);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
    repeat (200) @(posedge clk);
    $display("Sent %0d samples, completed %0d frames, checked %0d bins, %0d mismatches.",
             NSAMPLES, frames_done, bins_seen, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
